### hw/rtl/chrl_pkg.sv
package chrl_pkg;

    localparam int HASH_W     = 32;
    localparam int ID_W       = 4;
    localparam int CHAR_W     = 8;
    localparam int SHIFT_LO   = 6;
    localparam int SHIFT_HI   = 16;
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 2;

    typedef logic [HASH_W-1:0] hash_t;
    typedef logic [ID_W-1:0]   id_t;

    typedef enum logic [1:0] {
        ACT_SERVER = 2'd0,
        ACT_KEY    = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_MAPPED   = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_INSERTED = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic  insert;
        hash_t key;
        id_t   id;
    } ring_ctrl_t;

    // fold one byte into the sdbm hash, modulo 2^32
    function automatic hash_t fold_byte(hash_t h, logic [CHAR_W-1:0] c);
        hash_t ext;
        ext = {{(HASH_W-CHAR_W){1'b0}}, c};
        return ext + (h << SHIFT_LO) + (h << SHIFT_HI) - h;
    endfunction

endpackage

### hw/rtl/chrl_cell.sv
module chrl_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                 clk,
    input  chrl_pkg::ring_ctrl_t ctrl,
    input  logic [CNT_W-1:0]     count,
    input  logic                 prev_gt,
    input  chrl_pkg::hash_t      prev_hash,
    input  chrl_pkg::id_t        prev_id,
    output logic                 gt,
    output logic                 ge,
    output chrl_pkg::hash_t      hash,
    output chrl_pkg::id_t        id
);

    chrl_pkg::hash_t hash_reg;
    chrl_pkg::hash_t hash_next;
    chrl_pkg::id_t   id_reg;
    chrl_pkg::id_t   id_next;
    logic            occupied;
    logic            at_end;

    // compare the held entry against the key
    assign occupied = count > CNT_W'(INDEX);
    assign at_end   = count == CNT_W'(INDEX);
    assign gt       = occupied && (hash_reg > ctrl.key);
    assign ge       = occupied && (hash_reg >= ctrl.key);
    assign hash     = hash_reg;
    assign id       = id_reg;

    // shift up from the neighbor, or take the new entry at the insert point
    always_comb
    begin
        hash_next = hash_reg;
        id_next   = id_reg;
        if (ctrl.insert)
        begin
            if (prev_gt)
            begin
                hash_next = prev_hash;
                id_next   = prev_id;
            end
            else if (gt || at_end)
            begin
                hash_next = ctrl.key;
                id_next   = ctrl.id;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        id_reg   <= id_next;
    end

endmodule

### hw/rtl/consistent_hash_ring_lookup_core.sv
// A completed string's hash is registered in stage one and then in the result register.
// Input takes one byte per cycle while stage one can move on; hash folding and the ring
// update are registered, and the cells compare every entry in parallel for insertion and lookup.
// Output backpressure stalls the result stage; input is held off only while it is full.
// Reset (rst_n, async, active low) empties the ring and zeroes the hash and id counters.
module consistent_hash_ring_lookup_core #(
    parameter int RING_SIZE = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [chrl_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] char_byte
    input  logic [chrl_pkg::IN_USER_W-1:0]    s_tuser,   // [1:0] action
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [chrl_pkg::OUT_DATA_W-1:0]   m_tdata,   // [3:0] server_id, [35:4] server_hash,
                                                         // [67:36] string_hash, [71:68] zero
    output logic [chrl_pkg::OUT_USER_W-1:0]   m_tuser    // [1:0] status
);

    localparam int CNT_W = $clog2(RING_SIZE + 1);

    chrl_pkg::action_t   in_action;
    logic                in_accept;
    chrl_pkg::hash_t     folded;

    chrl_pkg::hash_t     run_hash_reg;
    chrl_pkg::hash_t     run_hash_next;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    chrl_pkg::action_t   s1_action_reg;
    chrl_pkg::action_t   s1_action_next;
    chrl_pkg::hash_t     s1_hash_reg;
    chrl_pkg::hash_t     s1_hash_next;
    logic                s1_load;
    logic                s1_go;
    logic                s1_clear;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    chrl_pkg::id_t       next_id_reg;
    chrl_pkg::id_t       next_id_next;
    logic                ring_full;
    logic                ring_empty;

    logic                out_valid_reg;
    logic                out_valid_next;
    chrl_pkg::status_t   out_status_reg;
    chrl_pkg::status_t   out_status_next;
    chrl_pkg::id_t       out_id_reg;
    chrl_pkg::id_t       out_id_next;
    chrl_pkg::hash_t     out_shash_reg;
    chrl_pkg::hash_t     out_shash_next;
    chrl_pkg::hash_t     out_strhash_reg;
    chrl_pkg::hash_t     out_strhash_next;
    logic                result_fire;

    chrl_pkg::ring_ctrl_t ctrl;
    logic [RING_SIZE-1:0] gt_vec;
    logic [RING_SIZE-1:0] ge_vec;
    logic [RING_SIZE-1:0] sel_vec;
    logic [RING_SIZE-1:0] pick_vec;
    chrl_pkg::hash_t      cell_hash [RING_SIZE];
    chrl_pkg::id_t        cell_id   [RING_SIZE];
    chrl_pkg::hash_t      hit_hash;
    chrl_pkg::id_t        hit_id;

    // input side: fold bytes into the running hash
    assign in_action = chrl_pkg::action_t'(s_tuser);
    assign in_accept = s_tvalid && s_tready;
    assign folded    = chrl_pkg::fold_byte(run_hash_reg, s_tdata);

    always_comb
    begin
        run_hash_next = run_hash_reg;
        s1_load       = 1'b0;
        if (in_accept)
        begin
            case (in_action)
                chrl_pkg::ACT_SERVER,
                chrl_pkg::ACT_KEY:
                begin
                    run_hash_next = s_tlast ? '0 : folded;
                    s1_load       = s_tlast;
                end
                chrl_pkg::ACT_CLEAR:
                begin
                    run_hash_next = '0;
                    s1_load       = 1'b1;
                end
                default:
                begin
                    run_hash_next = run_hash_reg;
                end
            endcase
        end
    end

    // stage one: hold a completed string or a clear until the ring takes it
    assign s1_clear = s1_action_reg == chrl_pkg::ACT_CLEAR;
    assign s1_go    = s1_valid_reg && (s1_clear || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_go;

    always_comb
    begin
        s1_valid_next  = s1_load || (s1_valid_reg && !s1_go);
        s1_action_next = s1_load ? in_action : s1_action_reg;
        s1_hash_next   = s1_load ? folded : s1_hash_reg;
    end

    // ring control
    assign ring_full  = count_reg >= CNT_W'(RING_SIZE);
    assign ring_empty = count_reg == '0;

    always_comb
    begin
        ctrl.insert = s1_go && (s1_action_reg == chrl_pkg::ACT_SERVER) && !ring_full;
        ctrl.key    = s1_hash_reg;
        ctrl.id     = next_id_reg;
    end

    always_comb
    begin
        count_next   = count_reg;
        next_id_next = next_id_reg;
        if (s1_go && s1_clear)
        begin
            count_next   = '0;
            next_id_next = '0;
        end
        else if (ctrl.insert)
        begin
            count_next   = count_reg + 1'b1;
            next_id_next = next_id_reg + 1'b1;
        end
    end

    // chain of cells; on insert, each entry above the insert point shifts to the next cell
    for (genvar i = 0; i < RING_SIZE; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            chrl_cell #(
                .INDEX (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .count     (count_reg),
                .prev_gt   (1'b0),
                .prev_hash ('0),
                .prev_id   ('0),
                .gt        (gt_vec[i]),
                .ge        (ge_vec[i]),
                .hash      (cell_hash[i]),
                .id        (cell_id[i])
            );
            assign sel_vec[i] = ge_vec[i];
        end
        else
        begin : g_rest
            chrl_cell #(
                .INDEX (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .count     (count_reg),
                .prev_gt   (gt_vec[i-1]),
                .prev_hash (cell_hash[i-1]),
                .prev_id   (cell_id[i-1]),
                .gt        (gt_vec[i]),
                .ge        (ge_vec[i]),
                .hash      (cell_hash[i]),
                .id        (cell_id[i])
            );
            assign sel_vec[i] = ge_vec[i] && !ge_vec[i-1];
        end
    end

    // pick the first entry not below the key, wrap to the first entry
    assign pick_vec = (|ge_vec) ? sel_vec : {{(RING_SIZE-1){1'b0}}, 1'b1};

    always_comb
    begin
        hit_hash = '0;
        hit_id   = '0;
        for (int i = 0; i < RING_SIZE; i++)
        begin
            if (pick_vec[i])
            begin
                hit_hash = hit_hash | cell_hash[i];
                hit_id   = hit_id | cell_id[i];
            end
        end
    end

    // result register
    assign result_fire = s1_go && !s1_clear;

    always_comb
    begin
        out_valid_next   = result_fire || (out_valid_reg && !m_tready);
        out_status_next  = out_status_reg;
        out_id_next      = out_id_reg;
        out_shash_next   = out_shash_reg;
        out_strhash_next = out_strhash_reg;
        if (result_fire)
        begin
            out_strhash_next = s1_hash_reg;
            out_id_next      = '0;
            out_shash_next   = '0;
            if (s1_action_reg == chrl_pkg::ACT_SERVER)
            begin
                if (ring_full)
                begin
                    out_status_next = chrl_pkg::ST_FULL;
                end
                else
                begin
                    out_status_next = chrl_pkg::ST_INSERTED;
                    out_id_next     = next_id_reg;
                    out_shash_next  = s1_hash_reg;
                end
            end
            else if (ring_empty)
            begin
                out_status_next = chrl_pkg::ST_EMPTY;
            end
            else
            begin
                out_status_next = chrl_pkg::ST_MAPPED;
                out_id_next     = hit_id;
                out_shash_next  = hit_hash;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'b0, out_strhash_reg, out_shash_reg, out_id_reg};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_hash_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            count_reg     <= '0;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_hash_reg  <= run_hash_next;
            s1_valid_reg  <= s1_valid_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_action_reg   <= s1_action_next;
        s1_hash_reg     <= s1_hash_next;
        out_status_reg  <= out_status_next;
        out_id_reg      <= out_id_next;
        out_shash_reg   <= out_shash_next;
        out_strhash_reg <= out_strhash_next;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RING_SIZE))
        else $error("ring count beyond ring size");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_clear |=> count_reg == '0)
        else $error("clear did not empty the ring");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.insert |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the ring by one");

    a_ring_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $onehot0(sel_vec))
        else $error("ring entries out of order");
`endif

endmodule
